@@ rtl/dkf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkf_pkg
// Shared types, constants and the micro-program of the distance Kalman filter.
// ----------------------------------------------------------------------------
package dkf_pkg;

  // Default number of fraction bits of the internal fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Register reset values and register indexes.
  localparam logic [23:0] PN_RESET = 24'd655;
  localparam logic [23:0] MN_RESET = 24'd6554;
  localparam logic CFG_PROCESS_NOISE = 1'b0;
  localparam logic CFG_MEASUREMENT_NOISE = 1'b1;

  // One second is 2^USEC_POW2 * USEC_ODD microseconds. The odd factor is divided
  // out by a multiply with USEC_RECIP and a right shift by USEC_RECIP_SH, which
  // is exact for every 32-bit dividend.
  localparam int          USEC_POW2     = 6;
  localparam logic [31:0] USEC_ODD      = 32'd15625;
  localparam logic [31:0] USEC_RECIP    = 32'd2251799814;
  localparam int          USEC_RECIP_SH = 45;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_INIT,
    OP_DT_Q0,
    OP_DT_REM,
    OP_DT_Q1,
    OP_DT_FIN,
    OP_MUL_RDT,
    OP_D_PRED,
    OP_A,
    OP_MUL_DTA,
    OP_P_PRED,
    OP_S,
    OP_K0_DIV,
    OP_K0_FIN,
    OP_K1_DIV,
    OP_K1_FIN,
    OP_Y,
    OP_MUL_K0Y,
    OP_D_UPD,
    OP_R_UPD,
    OP_P10_UPD,
    OP_P11_UPD,
    OP_P01_UPD,
    OP_P00_UPD
  } op_t;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PROG_LAST = 5'd21;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_t  op;
    logic load;
    logic out_load;
  } dkf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic initialised;
    logic div_busy;
    logic div_done;
  } dkf_status_t;

  // Micro-program of one predict and update pass.
  function automatic op_t prog(input logic [PC_W-1:0] pc);
    op_t op;
    case (pc)
      5'd0:    op = OP_DT_Q0;
      5'd1:    op = OP_DT_REM;
      5'd2:    op = OP_DT_Q1;
      5'd3:    op = OP_DT_FIN;
      5'd4:    op = OP_MUL_RDT;
      5'd5:    op = OP_D_PRED;
      5'd6:    op = OP_A;
      5'd7:    op = OP_MUL_DTA;
      5'd8:    op = OP_P_PRED;
      5'd9:    op = OP_S;
      5'd10:   op = OP_K0_DIV;
      5'd11:   op = OP_K0_FIN;
      5'd12:   op = OP_K1_DIV;
      5'd13:   op = OP_K1_FIN;
      5'd14:   op = OP_Y;
      5'd15:   op = OP_MUL_K0Y;
      5'd16:   op = OP_D_UPD;
      5'd17:   op = OP_R_UPD;
      5'd18:   op = OP_P10_UPD;
      5'd19:   op = OP_P11_UPD;
      5'd20:   op = OP_P01_UPD;
      5'd21:   op = OP_P00_UPD;
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/dkf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkf_in_if / dkf_out_if
// Valid/ready channels for measurement beats and result beats.
// ----------------------------------------------------------------------------
interface dkf_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] measured_distance;
  logic [31:0] elapsed_us;

  modport source (output valid, measured_distance, elapsed_us, input ready);
  modport sink (input valid, measured_distance, elapsed_us, output ready);
endinterface

interface dkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_distance;
  logic signed [31:0] distance_rate;
  logic               was_first;

  modport source (output valid, filtered_distance, distance_rate, was_first, input ready);
  modport sink (input valid, filtered_distance, distance_rate, was_first, output ready);
endinterface

@@ rtl/dkf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dkf_div #(
  parameter int NW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quot_r, quot_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   rem_sh;
  logic          fits;

  // One trial subtraction per cycle.
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quot_nxt = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      quot_nxt = {quot_r[NW-2:0], fits};
      num_nxt  = {num_r[NW-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the operands are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ rtl/dkf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkf_ctrl
// Sequencer that steps the datapath through the filter micro-program.
// ----------------------------------------------------------------------------
module dkf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dkf_pkg::dkf_status_t status,
  output dkf_pkg::dkf_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [dkf_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  dkf_pkg::op_t              run_op;

  // The first beat only initializes; later beats run the program.
  assign run_op = status.initialised ? dkf_pkg::prog(pc_r) : dkf_pkg::OP_INIT;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = dkf_pkg::OP_NOP;
    cmd.load      = 1'b0;
    cmd.out_load  = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          pc_nxt    = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.op = run_op;
        if (run_op inside {dkf_pkg::OP_K0_DIV, dkf_pkg::OP_K1_DIV}) begin
          state_nxt = ST_WAIT;
        end else if (run_op == dkf_pkg::OP_INIT || pc_r == dkf_pkg::PROG_LAST) begin
          state_nxt = ST_OUT;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (status.div_done) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_OUT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/dkf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkf_dp
// Filter datapath: state registers, shared multiplier and shared divider.
// ----------------------------------------------------------------------------
module dkf_dp #(
  parameter int FRAC_BITS = dkf_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dkf_pkg::dkf_cmd_t   cmd,
  output dkf_pkg::dkf_status_t status,
  input  logic [23:0]         in_measured_distance,
  input  logic [31:0]         in_elapsed_us,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_wdata,
  output logic signed [31:0]  out_filtered_distance,
  output logic signed [31:0]  out_distance_rate,
  output logic                out_was_first
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int DT_SH = FRAC_BITS - dkf_pkg::USEC_POW2;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] DT_MIN = 32'((64'd1 << FRAC_BITS) / 20);
  localparam logic [NW-1:0] MAG_MAX = NW'(64'h7FFF_FFFF);
  localparam logic [NW-1:0] MAG_MIN = NW'(64'h8000_0000);

  // Saturate an exact 34-bit sum to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    if (x > 34'sh0_7FFF_FFFF) return S32_MAX;
    if (x < -34'sh0_8000_0000) return S32_MIN;
    return x[31:0];
  endfunction

  // Product shifted down with floor rounding, then saturated.
  function automatic logic signed [31:0] qm(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sh = p >>> FRAC_BITS;
    if (sh > 64'sh7FFF_FFFF) return S32_MAX;
    if (sh < -64'sh8000_0000) return S32_MIN;
    return sh[31:0];
  endfunction

  // Unsigned Q8.16 value moved to the internal format.
  function automatic logic signed [31:0] conv(input logic [23:0] v);
    logic [31:0] w;
    w = {v, 8'b0} >> (24 - FRAC_BITS);
    return w[31] ? S32_MAX : $signed(w);
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  // Signed gain from the unsigned quotient magnitude.
  function automatic logic signed [31:0] kfin(input logic signed [31:0] n,
                                              input logic signed [31:0] d,
                                              input logic [NW-1:0] q);
    if (d == 32'sd0) return 32'sd0;
    if (n[31] ^ d[31]) begin
      if (q > MAG_MIN) return S32_MIN;
      return 32'(-q[31:0]);
    end
    if (q > MAG_MAX) return S32_MAX;
    return q[31:0];
  endfunction

  logic [23:0]        meas_r;
  logic [31:0]        el_r;
  logic [23:0]        pn_r, mn_r;
  logic               init_r, first_r;
  logic signed [31:0] d_r, r_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] dt_r, q_r, rn_r, a_r, s_r, k0_r, k1_r, y_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] fd_r, dr_r;
  logic               wf_r;
  logic [31:0]        dq0_r, drem_r, dq1_r;

  logic signed [31:0] z;
  logic signed [31:0] pq;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_c;
  logic               div_start, div_busy, div_done;
  logic [NW-1:0]      div_num, div_quot;
  logic [31:0]        div_den;
  logic [31:0]        dtm_a;
  logic [63:0]        dtm_c;
  logic [63:0]        dt_sum;
  logic signed [31:0] dt_sat;

  assign z  = conv(meas_r);
  assign pq = qm(prod_r);

  // Multiplier operands for the product used by the next step.
  always_comb begin
    case (cmd.op)
      dkf_pkg::OP_MUL_RDT: begin mul_a = r_r;  mul_b = dt_r;  end
      dkf_pkg::OP_D_PRED:  begin mul_a = dt_r; mul_b = p11_r; end
      dkf_pkg::OP_MUL_DTA: begin mul_a = dt_r; mul_b = sat34(34'(a_r) + 34'(p10_r)); end
      dkf_pkg::OP_D_UPD:   begin mul_a = k1_r; mul_b = y_r;   end
      dkf_pkg::OP_R_UPD:   begin mul_a = k1_r; mul_b = p00_r; end
      dkf_pkg::OP_P10_UPD: begin mul_a = k1_r; mul_b = p01_r; end
      dkf_pkg::OP_P11_UPD: begin mul_a = k0_r; mul_b = p01_r; end
      dkf_pkg::OP_P01_UPD: begin mul_a = k0_r; mul_b = p00_r; end
      default:             begin mul_a = k0_r; mul_b = y_r;   end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // Time step: the odd factor of one million is divided out by a reciprocal
  // multiply, first from the elapsed count and then from the scaled remainder.
  // The quotient is q0 * 2^DT_SH plus the quotient of the remainder.
  assign dtm_a  = (cmd.op == dkf_pkg::OP_DT_Q1) ? (drem_r << DT_SH) : el_r;
  assign dtm_c  = 64'(dtm_a) * 64'(dkf_pkg::USEC_RECIP);
  assign dt_sum = (64'(dq0_r) << DT_SH) + 64'(dq1_r);
  assign dt_sat = (dt_sum > 64'h7FFF_FFFF) ? S32_MAX : $signed(dt_sum[31:0]);

  // Divider operands for the two gains.
  always_comb begin
    div_start = 1'b0;
    div_num   = {mag(p00_r), {FRAC_BITS{1'b0}}};
    div_den   = mag(s_r);
    case (cmd.op)
      dkf_pkg::OP_K0_DIV: begin
        div_start = 1'b1;
      end
      dkf_pkg::OP_K1_DIV: begin
        div_start = 1'b1;
        div_num   = {mag(p10_r), {FRAC_BITS{1'b0}}};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  dkf_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r <= dkf_pkg::PN_RESET;
      mn_r <= dkf_pkg::MN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == dkf_pkg::CFG_PROCESS_NOISE) begin
        pn_r <= cfg_wdata;
      end else begin
        mn_r <= cfg_wdata;
      end
    end
  end

  // Filter state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b0;
      d_r    <= '0;
      r_r    <= '0;
    end else begin
      case (cmd.op)
        dkf_pkg::OP_INIT: begin
          init_r <= 1'b1;
          d_r    <= z;
          r_r    <= '0;
        end
        dkf_pkg::OP_D_PRED: d_r <= sat34(34'(d_r) + 34'(pq));
        dkf_pkg::OP_D_UPD:  d_r <= sat34(34'(d_r) + 34'(pq));
        dkf_pkg::OP_R_UPD:  r_r <= sat34(34'(r_r) + 34'(pq));
        default: begin
          init_r <= init_r;
        end
      endcase
    end
  end

  // Covariance and working registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    if (cmd.load) begin
      meas_r  <= in_measured_distance;
      el_r    <= in_elapsed_us;
      first_r <= 1'b0;
    end
    if (cmd.out_load) begin
      fd_r <= d_r;
      dr_r <= r_r;
      wf_r <= first_r;
    end
    case (cmd.op)
      dkf_pkg::OP_INIT: begin
        first_r <= 1'b1;
        p00_r   <= ONE_Q;
        p01_r   <= '0;
        p10_r   <= '0;
        p11_r   <= ONE_Q;
      end
      dkf_pkg::OP_DT_Q0:  dq0_r  <= 32'(dtm_c >> dkf_pkg::USEC_RECIP_SH);
      dkf_pkg::OP_DT_REM: drem_r <= el_r - dq0_r * dkf_pkg::USEC_ODD;
      dkf_pkg::OP_DT_Q1:  dq1_r  <= 32'(dtm_c >> dkf_pkg::USEC_RECIP_SH);
      dkf_pkg::OP_DT_FIN: begin
        dt_r <= (dt_sat < DT_MIN) ? DT_MIN : dt_sat;
        q_r  <= conv(pn_r);
        rn_r <= conv(mn_r);
      end
      dkf_pkg::OP_A: a_r <= pq;
      dkf_pkg::OP_P_PRED: begin
        p00_r <= sat34(34'(p00_r) + 34'(pq) + 34'(q_r));
        p01_r <= sat34(34'(p01_r) + 34'(a_r) + 34'(q_r));
        p10_r <= sat34(34'(p10_r) + 34'(a_r) + 34'(q_r));
        p11_r <= sat34(34'(p11_r) + 34'(q_r));
      end
      dkf_pkg::OP_S:       s_r   <= sat34(34'(p00_r) + 34'(rn_r));
      dkf_pkg::OP_K0_FIN:  k0_r  <= kfin(p00_r, s_r, div_quot);
      dkf_pkg::OP_K1_FIN:  k1_r  <= kfin(p10_r, s_r, div_quot);
      dkf_pkg::OP_Y:       y_r   <= sat34(34'(z) - 34'(d_r));
      dkf_pkg::OP_P10_UPD: p10_r <= sat34(34'(p10_r) - 34'(pq));
      dkf_pkg::OP_P11_UPD: p11_r <= sat34(34'(p11_r) - 34'(pq));
      dkf_pkg::OP_P01_UPD: p01_r <= sat34(34'(p01_r) - 34'(pq));
      dkf_pkg::OP_P00_UPD: p00_r <= sat34(34'(p00_r) - 34'(pq));
      default: begin
        a_r <= a_r;
      end
    endcase
  end

  assign status.initialised = init_r;
  assign status.div_busy    = div_busy;
  assign status.div_done    = div_done;

  assign out_filtered_distance = fd_r;
  assign out_distance_rate     = dr_r;
  assign out_was_first         = wf_r;

endmodule

@@ rtl/distance_kalman_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_kalman_filter_unit
// One-dimensional constant-velocity Kalman filter on distance measurements.
// ----------------------------------------------------------------------------
// Each measurement beat yields one result beat with the filtered distance and
// rate in signed fixed point with FRAC_BITS fraction bits. The first beat after
// reset only initializes the filter; its result passes through the run and
// output states and is valid with was_first set. Every later beat runs the
// micro-program, and the input opens again in the same cycle as its result
// becomes valid. The two gains each go through the shared bit-serial divider,
// one quotient bit per cycle over 32 + FRAC_BITS bits; the time step comes from
// two multiplications by a fixed reciprocal, and the remaining arithmetic is a
// single registered multiplier stepped by the controller, 22 steps in all. One
// beat is processed at a time; the next measurement is taken while the previous
// result still waits in the output register, and a result that cannot leave
// holds the following beat back. Configuration is sampled when each time step
// is finished, so a write made while idle takes effect from the next
// measurement on.
module distance_kalman_filter_unit #(
  parameter int FRAC_BITS = dkf_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  dkf_in_if.sink       in_chan,
  dkf_out_if.source    out_chan,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_wdata
);

  dkf_pkg::dkf_cmd_t    cmd;
  dkf_pkg::dkf_status_t status;

  // Sequencer.
  dkf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  dkf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .in_measured_distance  (in_chan.measured_distance),
    .in_elapsed_us         (in_chan.elapsed_us),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .out_filtered_distance (out_chan.filtered_distance),
    .out_distance_rate     (out_chan.distance_rate),
    .out_was_first         (out_chan.was_first)
  );

  // A taken beat closes the input until its result is produced.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while a beat is in work");

  // The divider is never restarted while it is still iterating.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == dkf_pkg::OP_K0_DIV || cmd.op == dkf_pkg::OP_K1_DIV) |-> !status.div_busy)
    else $error("divider started while busy");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_chan.valid || out_chan.ready))
    else $error("result overwrote a pending beat");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for distance_kalman_filter_unit.
// ----------------------------------------------------------------------------
// Measurement beats go in through a valid/ready channel with random gaps, and
// result beats are taken with random back-pressure. A local fixed-point model
// of the filter predicts every result. A short table of directed steps
// (extremes, minimum time step, zero and full-scale noise) runs first. Random
// phases follow, each under its own noise setting. The register writes happen
// only while the filter is idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam int  RAND_ITEMS = 950;
  localparam int  PHASES = 5;
  localparam logic signed [31:0] ONE_Q = 32'sd65536;
  localparam longint DT_FLOOR = 64'sd65536 / 20;

  typedef struct {
    logic signed [31:0] distance;
    logic signed [31:0] rate;
    logic               first;
  } filt_result_t;

  typedef struct {
    bit                 is_cfg;
    logic               reg_idx;
    logic [23:0]        value;
    logic [31:0]        elapsed;
    bit                 typed;
    logic signed [31:0] distance;
    logic signed [31:0] rate;
    logic               first;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we, cfg_index;
  logic [23:0] cfg_wdata;
  int cycles = 0;
  int err_count = 0;

  dkf_in_if  in_chan();
  dkf_out_if out_chan();

  distance_kalman_filter_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Filter state as the bench expects it to be.
  logic signed [31:0] est_dist, est_rate;
  logic signed [31:0] cov [4];
  bit                 filt_on;
  logic [23:0]        noise_q, noise_r;
  filt_result_t       pending_results[$];

  function automatic logic signed [31:0] sat32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [31:0] num,
                                                input logic signed [31:0] den);
    if (den == 0) return 0;
    return sat32((longint'(num) * 64'sd65536) / longint'(den));
  endfunction

  // Advance the local filter by one measurement and return its result.
  function automatic filt_result_t kalman_step(input logic [23:0] z_raw,
                                               input logic [31:0] el);
    filt_result_t res;
    logic signed [31:0] z, dt, q, rn, a, s, k0, k1, y, p00, p01;
    longint dt64;
    z = {8'd0, z_raw};
    res.first = !filt_on;
    if (!filt_on) begin
      est_dist = z;
      est_rate = 0;
      cov[0] = ONE_Q; cov[1] = 0; cov[2] = 0; cov[3] = ONE_Q;
      filt_on = 1'b1;
    end else begin
      dt64 = (longint'({32'd0, el}) * 64'sd65536) / 64'sd1000000;
      if (dt64 < DT_FLOOR) dt64 = DT_FLOOR;
      dt = sat32(dt64);
      q  = {8'd0, noise_q};
      rn = {8'd0, noise_r};
      // Predict over the elapsed interval.
      est_dist = sat32(longint'(est_dist) + fx_mul(est_rate, dt));
      a = fx_mul(dt, cov[3]);
      cov[0] = sat32(longint'(cov[0]) + fx_mul(dt, sat32(longint'(a) + cov[2])) + q);
      cov[1] = sat32(longint'(cov[1]) + a + q);
      cov[2] = sat32(longint'(cov[2]) + a + q);
      cov[3] = sat32(longint'(cov[3]) + q);
      // Measurement update.
      s  = sat32(longint'(cov[0]) + rn);
      k0 = fx_div(cov[0], s);
      k1 = fx_div(cov[2], s);
      y  = sat32(longint'(z) - est_dist);
      est_dist = sat32(longint'(est_dist) + fx_mul(k0, y));
      est_rate = sat32(longint'(est_rate) + fx_mul(k1, y));
      p00 = cov[0];
      p01 = cov[1];
      cov[0] = sat32(longint'(cov[0]) - fx_mul(k0, p00));
      cov[1] = sat32(longint'(cov[1]) - fx_mul(k0, p01));
      cov[2] = sat32(longint'(cov[2]) - fx_mul(k1, p00));
      cov[3] = sat32(longint'(cov[3]) - fx_mul(k1, p01));
    end
    res.distance = est_dist;
    res.rate = est_rate;
    return res;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // Present one measurement beat and hold it until it is taken.
  task automatic send_meas(input logic [23:0] z, input logic [31:0] el,
                           input bit typed, input filt_result_t typed_res);
    filt_result_t res;
    int n;
    in_chan.valid <= 1'b1;
    in_chan.measured_distance <= z;
    in_chan.elapsed_us <= el;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    res = kalman_step(z, el);
    pending_results.push_back(typed ? typed_res : res);
    n = gap_len();
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Register write, issued only once every result has come back.
  task automatic write_reg(input logic idx, input logic [23:0] value);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dkf_pkg::CFG_PROCESS_NOISE) noise_q = value;
    else noise_r = value;
  endtask

  // Result side: random back-pressure.
  initial begin
    int n;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_chan.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    filt_result_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat");
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_chan.filtered_distance !== e.distance) begin
          $error("filtered_distance: expected %0d, got %0d", e.distance,
                 out_chan.filtered_distance);
          err_count++;
        end
        if (out_chan.distance_rate !== e.rate) begin
          $error("distance_rate: expected %0d, got %0d", e.rate, out_chan.distance_rate);
          err_count++;
        end
        if (out_chan.was_first !== e.first) begin
          $error("was_first: expected %0d, got %0d", e.first, out_chan.was_first);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    step_t steps [21] = '{
      '{0, 0, 24'hFFFFFF, 32'd0,          1, 32'sh00FFFFFF, 32'sd0, 1'b1},
      '{0, 0, 24'h000000, 32'd0,          0, 0, 0, 0},
      '{0, 0, 24'hFFFFFF, 32'hFFFFFFFF,   0, 0, 0, 0},
      '{0, 0, 24'h010000, 32'd49999,      0, 0, 0, 0},
      '{0, 0, 24'h010000, 32'd50000,      0, 0, 0, 0},
      '{0, 0, 24'h020000, 32'd1000000,    0, 0, 0, 0},
      '{1, dkf_pkg::CFG_PROCESS_NOISE, 24'd0, 0,     0, 0, 0, 0},
      '{1, dkf_pkg::CFG_MEASUREMENT_NOISE, 24'd0, 0, 0, 0, 0, 0},
      '{0, 0, 24'h020000, 32'd100000,     0, 0, 0, 0},
      '{0, 0, 24'h020000, 32'd100000,     0, 0, 0, 0},
      '{0, 0, 24'h030000, 32'd1,          0, 0, 0, 0},
      '{0, 0, 24'h000000, 32'h80000000,   0, 0, 0, 0},
      '{1, dkf_pkg::CFG_PROCESS_NOISE, 24'hFFFFFF, 0,     0, 0, 0, 0},
      '{1, dkf_pkg::CFG_MEASUREMENT_NOISE, 24'hFFFFFF, 0, 0, 0, 0, 0},
      '{0, 0, 24'hFFFFFF, 32'hFFFFFFFF,   0, 0, 0, 0},
      '{0, 0, 24'h000000, 32'hFFFFFFFF,   0, 0, 0, 0},
      '{0, 0, 24'hAAAAAA, 32'h55555555,   0, 0, 0, 0},
      '{0, 0, 24'h555555, 32'hAAAAAAAA,   0, 0, 0, 0},
      '{1, dkf_pkg::CFG_PROCESS_NOISE, 24'd655, 0,      0, 0, 0, 0},
      '{1, dkf_pkg::CFG_MEASUREMENT_NOISE, 24'd6554, 0, 0, 0, 0, 0},
      '{0, 0, 24'h123456, 32'd100000,     0, 0, 0, 0}
    };
    filt_result_t typed_res;
    logic [23:0] z_walk;
    logic [31:0] el;
    int r;

    in_chan.valid <= 1'b0;
    in_chan.measured_distance <= '0;
    in_chan.elapsed_us <= '0;
    cfg_we <= 1'b0;
    cfg_index <= dkf_pkg::CFG_PROCESS_NOISE;
    cfg_wdata <= '0;
    est_dist = 0;
    est_rate = 0;
    filt_on = 1'b0;
    noise_q = dkf_pkg::PN_RESET;
    noise_r = dkf_pkg::MN_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed steps.
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        write_reg(steps[i].reg_idx, steps[i].value);
      end else begin
        typed_res.distance = steps[i].distance;
        typed_res.rate = steps[i].rate;
        typed_res.first = steps[i].first;
        send_meas(steps[i].value, steps[i].elapsed, steps[i].typed, typed_res);
      end
    end

    // Random phases, each under its own noise setting.
    z_walk = 24'h030000;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(dkf_pkg::CFG_PROCESS_NOISE, 24'($urandom));
          write_reg(dkf_pkg::CFG_MEASUREMENT_NOISE, 24'($urandom));
        end
        1: begin
          write_reg(dkf_pkg::CFG_PROCESS_NOISE, 24'd0);
          write_reg(dkf_pkg::CFG_MEASUREMENT_NOISE, 24'd0);
        end
        2: begin
          write_reg(dkf_pkg::CFG_PROCESS_NOISE, 24'hFFFFFF);
          write_reg(dkf_pkg::CFG_MEASUREMENT_NOISE, 24'hFFFFFF);
        end
        3: begin
          write_reg(dkf_pkg::CFG_PROCESS_NOISE, dkf_pkg::PN_RESET);
          write_reg(dkf_pkg::CFG_MEASUREMENT_NOISE, dkf_pkg::MN_RESET);
        end
        default: begin
          write_reg(dkf_pkg::CFG_PROCESS_NOISE, 24'($urandom_range(0, 4096)));
          write_reg(dkf_pkg::CFG_MEASUREMENT_NOISE, 24'($urandom_range(0, 65536)));
        end
      endcase
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) begin
        r = $urandom_range(0, 99);
        // Mostly a plausible track: small moves at realistic intervals.
        if (r < 70) begin
          z_walk = z_walk + 24'($urandom_range(0, 8192)) - 24'd4096;
          el = $urandom_range(1000, 300000);
        end else begin
          z_walk = 24'($urandom);
          el = $urandom;
        end
        typed_res = '{0, 0, 0};
        send_meas(z_walk, el, 1'b0, typed_res);
      end
    end

    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
